### hdl/sitda_pkg.sv
// shared types and constants for the signed integer to decimal text converter
`default_nettype none

package sitda_pkg;

  // ascii codes of the characters the block produces
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  // a bcd digit at or above this value gets the add-3 correction before a shift
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } sitda_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture a new value and clear the digit register
    logic conv;      // one double-dabble step
    logic shift;     // drop the top digit
    logic out_load;  // fill the output register
    logic out_sign;  // output register gets the minus sign
  } sitda_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic conv_last; // this conversion step is the final one
    logic neg;       // value is negative
    logic skip;      // top digit is a leading zero that is not the final digit
    logic last_dig;  // top digit is the final digit
    logic out_free;  // output register can take a beat this cycle
  } sitda_sts_t;

endpackage

`default_nettype wire

### hdl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text converter. Each input beat carries one
// two's complement value of VALUE_BITS bits in the low bits of in_tdata; the block
// sends its decimal text as one character per output beat, most significant first,
// with a leading '-' for negative values, a single '0' for zero and tlast on the
// final digit. The most negative value converts to its full magnitude. One number
// passes an accept step, VALUE_BITS double-dabble steps (one bit a cycle through the
// bcd register), a sign step if negative, and one step per bcd digit slot (leading
// zeros are dropped at one a cycle); the sign and digit beats wait while the output
// is stalled. The last character sits in the output register while the next number
// is already accepted.
`default_nettype none

module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = 32,
  localparam int InWidth = ((VALUE_BITS + 7) / 8) * 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [InWidth-1:0] in_tdata,   // value
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [7:0]              out_tdata,  // char_code
  output logic                    out_tlast
);
  import sitda_pkg::*;

  sitda_cmd_t cmd;
  sitda_sts_t sts;

  // controller
  sitda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  sitda_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .value     (in_tdata[VALUE_BITS-1:0]),
    .cmd       (cmd),
    .sts       (sts),
    .char_code (out_tdata),
    .last      (out_tlast),
    .out_valid (out_tvalid),
    .out_ready (out_tready)
  );

endmodule

`default_nettype wire

### hdl/sitda_ctrl.sv
// controller state machine of the decimal text converter
`default_nettype none

module sitda_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire sitda_pkg::sitda_sts_t sts,
  output sitda_pkg::sitda_cmd_t    cmd
);
  import sitda_pkg::*;

  sitda_state_t state_r;
  sitda_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (sts.conv_last) state_nxt = sts.neg ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        if (sts.out_free) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.skip && sts.out_free && sts.last_dig) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
      end
      ST_SIGN: begin
        cmd.out_load = sts.out_free;
        cmd.out_sign = 1'b1;
      end
      ST_EMIT: begin
        // leading zeros are dropped without a beat
        if (sts.skip) begin
          cmd.shift = 1'b1;
        end else if (sts.out_free) begin
          cmd.shift    = 1'b1;
          cmd.out_load = 1'b1;
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/sitda_dp.sv
// datapath: magnitude, double-dabble bcd register and output register
`default_nettype none

module sitda_dp #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic [VALUE_BITS-1:0]   value,
  input  wire sitda_pkg::sitda_cmd_t   cmd,
  output sitda_pkg::sitda_sts_t        sts,
  output logic [7:0]                   char_code,
  output logic                         last,
  output logic                         out_valid,
  input  wire logic                    out_ready
);
  import sitda_pkg::*;

  // enough digits for any magnitude of VALUE_BITS bits
  localparam int NumDigits = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int BcdW      = NumDigits * 4;
  localparam int BitCntW   = $clog2(VALUE_BITS + 1);
  localparam int DigCntW   = $clog2(NumDigits + 1);

  function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
    bcd_adjust = (d >= BCD_ADJ_MIN) ? d + BCD_ADJ_ADD : d;
  endfunction

  logic [VALUE_BITS-1:0] mag_r,     mag_nxt;
  logic [BcdW-1:0]       bcd_r,     bcd_nxt;
  logic [BcdW-1:0]       bcd_adj;
  logic [BitCntW-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [DigCntW-1:0]    dig_cnt_r, dig_cnt_nxt;
  logic                  neg_r,     neg_nxt;
  logic                  lead_r,    lead_nxt;
  logic                  vld_r,     vld_nxt;
  logic [7:0]            char_r,    char_nxt;
  logic                  last_r,    last_nxt;
  logic [3:0]            top_dig;

  assign top_dig = bcd_r[BcdW-1 -: 4];

  // add-3 correction on every digit
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[4*i +: 4] = bcd_adjust(bcd_r[4*i +: 4]);
    end
  end

  // conversion registers
  always_comb begin
    mag_nxt     = mag_r;
    bcd_nxt     = bcd_r;
    bit_cnt_nxt = bit_cnt_r;
    dig_cnt_nxt = dig_cnt_r;
    neg_nxt     = neg_r;
    lead_nxt    = lead_r;
    if (cmd.load) begin
      neg_nxt     = value[VALUE_BITS-1];
      mag_nxt     = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
      bcd_nxt     = '0;
      bit_cnt_nxt = BitCntW'(VALUE_BITS);
      dig_cnt_nxt = DigCntW'(NumDigits);
      lead_nxt    = 1'b1;
    end else if (cmd.conv) begin
      {bcd_nxt, mag_nxt} = {bcd_adj, mag_r} << 1;
      bit_cnt_nxt        = bit_cnt_r - BitCntW'(1);
    end else if (cmd.shift) begin
      bcd_nxt     = bcd_r << 4;
      dig_cnt_nxt = dig_cnt_r - DigCntW'(1);
      if (cmd.out_load) lead_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    bcd_r     <= bcd_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    dig_cnt_r <= dig_cnt_nxt;
    neg_r     <= neg_nxt;
    lead_r    <= lead_nxt;
  end

  // output register
  always_comb begin
    vld_nxt  = vld_r;
    char_nxt = char_r;
    last_nxt = last_r;
    if (cmd.out_load) begin
      vld_nxt  = 1'b1;
      char_nxt = cmd.out_sign ? ASCII_MINUS : ASCII_ZERO + {4'b0000, top_dig};
      last_nxt = cmd.out_sign ? 1'b0 : sts.last_dig;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  // status
  assign sts.conv_last = (bit_cnt_r == BitCntW'(1));
  assign sts.neg       = neg_r;
  assign sts.last_dig  = (dig_cnt_r == DigCntW'(1));
  assign sts.skip      = lead_r && (top_dig == 4'd0) && (dig_cnt_r != DigCntW'(1));
  assign sts.out_free  = !vld_r || out_ready;

  assign char_code = char_r;
  assign last      = last_r;
  assign out_valid = vld_r;

endmodule

`default_nettype wire

### test/tb_signed_int_to_decimal_ascii.sv
// testbench for the signed integer to decimal ascii converter with its own text predictor
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii;
  import sitda_pkg::*;

  localparam int VALUE_BITS = 32;
  localparam int DEC_RADIX = 10;
  localparam int RANDOM_VALUES = 410;
  localparam int MAX_REPORTS = 10;
  localparam int TAIL_CYCLES = 60;

  // one expected character beat
  typedef struct {
    logic [7:0] char_code;
    logic       last;
  } text_char_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [VALUE_BITS-1:0] in_tdata = '0;   // value
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;       // char_code
  logic                  out_tlast;

  logic [VALUE_BITS-1:0] pending_values[$];
  text_char_t            expected_chars[$];
  int                    values_total = 0;
  int                    values_sent = 0;
  int                    char_errors = 0;

  // handshake flags passed from the sampling edge to the driving edge
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  int in_wait = 0;
  int out_wait = 0;
  int in_calm = 0;
  int out_calm = 0;

  signed_int_to_decimal_ascii #(.VALUE_BITS(VALUE_BITS)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // wait before the next beat: runs of zero waits mixed with random gaps
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(5, 30);
    return $urandom_range(0, 19);
  endfunction

  // decimal text of one value, sign first, digits most significant first
  function automatic void predict_decimal_text(logic [VALUE_BITS-1:0] value);
    logic [63:0]           magnitude;
    logic [VALUE_BITS-1:0] neg_value;
    logic [7:0]            digits[$];
    text_char_t            ch;
    // negate at the value width so the most negative value keeps its magnitude
    neg_value = -value;
    magnitude = value[VALUE_BITS-1] ? 64'(neg_value) : 64'(value);
    do begin
      digits.push_front(ASCII_ZERO + 8'(magnitude % DEC_RADIX));
      magnitude = magnitude / DEC_RADIX;
    end while (magnitude != 0);
    if (value[VALUE_BITS-1]) begin
      ch.char_code = ASCII_MINUS;
      ch.last = 1'b0;
      expected_chars.push_back(ch);
    end
    foreach (digits[i]) begin
      ch.char_code = digits[i];
      ch.last = (i == digits.size() - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  // random value: full range, near powers of ten, or a random digit count
  function automatic logic [VALUE_BITS-1:0] random_value();
    logic [63:0]           lo;
    logic [63:0]           hi;
    logic [VALUE_BITS-1:0] v;
    int                    ndig;
    ndig = $urandom_range(1, 10);
    lo = 1;
    repeat (ndig - 1) lo = lo * DEC_RADIX;
    case ($urandom_range(0, 3))
      0: v = $urandom();
      1: v = VALUE_BITS'(lo) + VALUE_BITS'($urandom_range(0, 2)) - 1'b1;
      default: begin
        hi = lo * DEC_RADIX - 1;
        if (hi > 64'h7fff_ffff) hi = 64'h7fff_ffff;
        if (ndig == 1) lo = 0;
        v = $urandom_range(32'(hi), 32'(lo));
      end
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // input driver
  always @(negedge clk) begin
    logic next_valid;
    next_valid = in_tvalid;
    if (rst_n) begin
      if (in_taken) begin
        in_taken = 1'b0;
        next_valid = 1'b0;
        in_wait = draw_wait(in_calm);
      end
      if (!next_valid && pending_values.size() > 0) begin
        if (in_wait > 0) begin
          in_wait--;
        end else begin
          in_tdata <= pending_values.pop_front();
          next_valid = 1'b1;
        end
      end
    end
    in_tvalid <= next_valid;
  end

  // output ready driver: may stall after each beat
  always @(negedge clk) begin
    logic next_ready;
    next_ready = 1'b0;
    if (rst_n) begin
      if (out_taken) begin
        out_taken = 1'b0;
        out_wait = draw_wait(out_calm);
      end
      if (out_wait > 0) begin
        out_wait--;
      end else begin
        next_ready = 1'b1;
      end
    end
    out_tready <= next_ready;
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_decimal_text(in_tdata);
        values_sent++;
        in_taken = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        out_taken = 1'b1;
        if (expected_chars.size() == 0) begin
          char_errors++;
          if (char_errors <= MAX_REPORTS)
            $display("%0t: unexpected beat char=%0d last=%0b", $realtime, out_tdata, out_tlast);
        end else begin
          want = expected_chars.pop_front();
          if (out_tdata !== want.char_code || out_tlast !== want.last) begin
            char_errors++;
            if (char_errors <= MAX_REPORTS)
              $display("%0t: mismatch char exp=%0d got=%0d last exp=%0b got=%0b",
                       $realtime, want.char_code, out_tdata, want.last, out_tlast);
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    pending_values = {
      32'd0, 32'd1, 32'hffff_ffff, 32'd9, 32'd10, -32'd10, 32'd99, 32'd100,
      32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
      -32'd999999999, 32'd1999999999, 32'd123456789, -32'd123456789, 32'd1000000,
      -32'd1000000000, 32'd8, -32'd9, 32'h5555_5555, 32'haaaa_aaaa
    };
    repeat (RANDOM_VALUES) pending_values.push_back(random_value());
    values_total = pending_values.size();
    in_wait = draw_wait(in_calm);

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    while (values_sent < values_total || expected_chars.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (char_errors == 0) begin
      $display("tb_signed_int_to_decimal_ascii: done, clean");
    end else begin
      $display("tb_signed_int_to_decimal_ascii: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("tb_signed_int_to_decimal_ascii: done, errors");
    $finish;
  end

endmodule
